[sv/lrup_pkg.sv]
`timescale 1ns / 1ps

package lrup_pkg;

    localparam int MAX_FRAMES  = 16;
    localparam int PAGE_BITS   = 16;
    localparam int FRAME_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int RANK_W      = FRAME_W;
    localparam int FIC_W       = $clog2(MAX_FRAMES + 1);
    localparam int CFG_W       = 5;
    localparam int FAULT_W     = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int TREE_LVLS   = FRAME_W;
    localparam int TREE_N      = 1 << TREE_LVLS;

    localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(4);

    // page reference waiting for the back end
    typedef struct packed {
        logic                 valid;
        logic [PAGE_BITS-1:0] page;
    } t_req;

    // one result word
    typedef struct packed {
        logic                 hit;
        logic [FRAME_W-1:0]   frame_index;
        logic                 evicted_valid;
        logic [PAGE_BITS-1:0] evicted_page;
        logic [FAULT_W-1:0]   fault_count;
    } t_result;

endpackage

[sv/lrup_in_queue.sv]
`timescale 1ns / 1ps

module lrup_in_queue import lrup_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [PAGE_BITS-1:0] i_page,
    input  logic                 i_take,
    output t_req                 o_req
);

    logic [PAGE_BITS-1:0] r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    r_wr;
    logic [QPTR_W-1:0]    r_rd;
    logic [QCNT_W-1:0]    r_count;
    logic                 w_push;
    logic                 w_pop;

    assign o_full    = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign w_push    = i_push && !o_full;
    assign w_pop     = i_take && (r_count != '0);
    assign o_req.valid = (r_count != '0);
    assign o_req.page  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= i_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[sv/lrup_engine.sv]
`timescale 1ns / 1ps

module lrup_engine import lrup_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  t_req             i_req,
    output logic             o_take,
    input  logic             i_res_ready,
    output logic             o_res_push,
    output t_result          o_result
);

    typedef struct packed {
        logic              ok;
        logic [RANK_W-1:0] rank;
        logic [FRAME_W-1:0] idx;
    } t_node;

    logic [CFG_W-1:0]     r_frames_in_use;
    logic [FIC_W-1:0]     r_fill;
    logic [PAGE_BITS-1:0] r_page [MAX_FRAMES];
    logic [RANK_W-1:0]    r_rank [MAX_FRAMES];
    logic [FAULT_W-1:0]   r_faults;
    logic [FAULT_W-1:0]   n_faults;

    logic [FIC_W-1:0]     w_active_n;
    logic [MAX_FRAMES-1:0] w_valid;
    logic [MAX_FRAMES-1:0] w_active;
    logic [MAX_FRAMES-1:0] w_match;
    logic                 w_hit;
    logic [FRAME_W-1:0]   w_hit_idx;
    logic [RANK_W-1:0]    w_hit_rank;
    logic                 w_has_empty;
    t_node                w_tree [TREE_LVLS+1][TREE_N];
    logic [FRAME_W-1:0]   w_target;
    logic [RANK_W:0]      w_limit;
    logic                 w_evict;
    logic                 w_fire;

    // clamp the frame count into 1..MAX_FRAMES
    always_comb begin
        if (r_frames_in_use == '0) begin
            w_active_n = FIC_W'(1);
        end else if (int'(r_frames_in_use) > MAX_FRAMES) begin
            w_active_n = FIC_W'(MAX_FRAMES);
        end else begin
            w_active_n = FIC_W'(r_frames_in_use);
        end
    end

    // frames fill from index zero up, so valid frames are those below the fill count
    always_comb begin
        w_hit_idx  = '0;
        w_hit_rank = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            w_valid[i]  = FIC_W'(i) < r_fill;
            w_active[i] = FIC_W'(i) < w_active_n;
            w_match[i]  = w_valid[i] && w_active[i] && (r_page[i] == i_req.page);
            // at most one frame holds a given page
            w_hit_idx  = w_hit_idx  | (w_match[i] ? FRAME_W'(i) : '0);
            w_hit_rank = w_hit_rank | (w_match[i] ? r_rank[i] : '0);
        end
        w_hit       = |w_match;
        w_has_empty = r_fill < w_active_n;
    end

    // registered-free oldest search: small compare tree, ties go to the lower index
    always_comb begin
        for (int i = 0; i < TREE_N; i++) begin
            if (i < MAX_FRAMES) begin
                w_tree[0][i].ok   = w_active[i];
                w_tree[0][i].rank = r_rank[i];
            end else begin
                w_tree[0][i].ok   = 1'b0;
                w_tree[0][i].rank = '0;
            end
            w_tree[0][i].idx = FRAME_W'(i);
        end
        for (int l = 0; l < TREE_LVLS; l++) begin
            for (int j = 0; j < TREE_N; j++) begin
                if (j < TREE_N / 2) begin
                    if (w_tree[l][2*j+1].ok &&
                        (!w_tree[l][2*j].ok || w_tree[l][2*j+1].rank > w_tree[l][2*j].rank))
                    begin
                        w_tree[l+1][j] = w_tree[l][2*j+1];
                    end else begin
                        w_tree[l+1][j] = w_tree[l][2*j];
                    end
                end else begin
                    w_tree[l+1][j] = '0;
                end
            end
        end
    end

    always_comb begin
        w_evict = !w_hit && !w_has_empty;
        if (w_hit) begin
            w_target = w_hit_idx;
            w_limit  = {1'b0, w_hit_rank};
        end else if (w_has_empty) begin
            w_target = r_fill[FRAME_W-1:0];
            w_limit  = (RANK_W+1)'(MAX_FRAMES);
        end else begin
            w_target = w_tree[TREE_LVLS][0].idx;
            w_limit  = {1'b0, w_tree[TREE_LVLS][0].rank};
        end
        n_faults = w_hit ? r_faults : r_faults + 1'b1;
    end

    assign w_fire     = i_req.valid && i_res_ready;
    assign o_take     = w_fire;
    assign o_res_push = w_fire;

    always_comb begin
        o_result.hit           = w_hit;
        o_result.frame_index   = w_target;
        o_result.evicted_valid = w_evict;
        o_result.evicted_page  = w_evict ? r_page[w_target] : '0;
        o_result.fault_count   = n_faults;
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_page[w_target] <= i_req.page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= FRAMES_RESET;
            r_fill          <= '0;
            r_faults        <= '0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_cfg_we) begin
            r_frames_in_use <= i_cfg_wdata;
            r_fill          <= '0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (w_fire) begin
            r_faults <= n_faults;
            if (!w_hit && w_has_empty) begin
                r_fill <= r_fill + 1'b1;
            end
            for (int i = 0; i < MAX_FRAMES; i++) begin
                if (FRAME_W'(i) == w_target) begin
                    r_rank[i] <= '0;
                end else if (w_valid[i] && w_active[i] && ({1'b0, r_rank[i]} < w_limit) &&
                             (r_rank[i] < RANK_W'(MAX_FRAMES - 1))) begin
                    r_rank[i] <= r_rank[i] + 1'b1;
                end
            end
        end
    end

endmodule

[sv/lrup_out_queue.sv]
`timescale 1ns / 1ps

module lrup_out_queue import lrup_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    output logic    o_ready,
    input  t_result i_data,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_data
);

    t_result           r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[sv/lru_page_replacement.sv]
`timescale 1ns / 1ps

// fully associative lru page replacement over up to 16 frames. each pushed page
// reference gives one result word: hit or fault, the frame that now holds the
// page, the page displaced if a resident one was evicted (zero otherwise) and
// the running 32-bit fault total. a miss fills the lowest empty frame first,
// then replaces the least recently used one (lowest index on a tie). the block
// sustains one reference per clock while the result queue has room: the back
// end does the 16-way tag compare and the oldest-frame search combinationally
// and updates the ranks of all frames at the edge that takes the reference. a
// reference passes through the input queue, the back end and the result queue;
// the input queue and the result queue each add one register stage. writing the
// frame count (0 acts as 1, above 16 acts as 16) empties every frame at once
// and keeps the fault total; write it only while no reference is in flight.
module lru_page_replacement import lrup_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [PAGE_BITS-1:0] i_page_number,
    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output logic                 empty,
    input  logic                 pop,
    output logic                 o_hit,
    output logic [FRAME_W-1:0]   o_frame_index,
    output logic                 o_evicted_valid,
    output logic [PAGE_BITS-1:0] o_evicted_page,
    output logic [FAULT_W-1:0]   o_fault_count
);

    t_req    w_req;
    logic    w_take;
    logic    w_res_ready;
    logic    w_res_push;
    t_result w_res;
    t_result w_head;

    // front: page references wait here until the back end is free
    lrup_in_queue u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_page  (i_page_number),
        .i_take  (w_take),
        .o_req   (w_req)
    );

    // back: frame table, lookup, victim choice and recency ranks
    lrup_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (w_req),
        .o_take      (w_take),
        .i_res_ready (w_res_ready),
        .o_res_push  (w_res_push),
        .o_result    (w_res)
    );

    // result words wait here for the consumer
    lrup_out_queue u_results (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .o_ready (w_res_ready),
        .i_data  (w_res),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (w_head)
    );

    assign o_hit           = w_head.hit;
    assign o_frame_index   = w_head.frame_index;
    assign o_evicted_valid = w_head.evicted_valid;
    assign o_evicted_page  = w_head.evicted_page;
    assign o_fault_count   = w_head.fault_count;

    // a hit never displaces a page
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_hit) |-> !o_evicted_valid)
        else $error("hit word reports an eviction");

    // no eviction means the evicted page field is zero
    a_evict_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_evicted_valid) |-> (o_evicted_page == '0))
        else $error("evicted page nonzero without eviction");

    // both queues come out of reset empty
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> (!full && empty))
        else $error("queues not empty after reset");

endmodule
